// File: hdl/qfsp_pkg.sv
// ----------------------------------------------------------------------------
// qfsp_pkg
// Shared constants and types for the quadratic-fit sub-pixel peak refiner.
// ----------------------------------------------------------------------------
package qfsp_pkg;

  localparam int COORD_BITS_DEF  = 12;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF   = 8;

  typedef enum logic [1:0] {
    MODE_FULL   = 2'd0,
    MODE_ROW    = 2'd1,
    MODE_COL    = 2'd2,
    MODE_CENTRE = 2'd3
  } edge_mode_t;

endpackage

// File: hdl/qfsp_fit.sv
// ----------------------------------------------------------------------------
// qfsp_fit
// Three-stage fit: weighted sums, products, then denominator and numerators
// reduced to sign and magnitude.
// ----------------------------------------------------------------------------
module qfsp_fit #(
  parameter int COORD_BITS  = qfsp_pkg::COORD_BITS_DEF,
  parameter int SAMPLE_BITS = qfsp_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [COORD_BITS-1:0]             in_row,
  input  logic [COORD_BITS-1:0]             in_col,
  input  qfsp_pkg::edge_mode_t              in_mode,
  input  logic signed [SAMPLE_BITS-1:0]     in_samp [9],
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [COORD_BITS-1:0]             out_row,
  output logic [COORD_BITS-1:0]             out_col,
  output logic [2*SAMPLE_BITS+16:0]         out_dmag,
  output logic [2*SAMPLE_BITS+16:0]         out_ncol,
  output logic [2*SAMPLE_BITS+16:0]         out_nrow,
  output logic                              out_neg_col,
  output logic                              out_neg_row
);
  import qfsp_pkg::*;

  localparam int AW = SAMPLE_BITS + 6;
  localparam int MW = 2 * AW;
  localparam int PW = 2 * AW + 5;

  logic signed [SAMPLE_BITS-1:0] z [9];
  logic signed [AW-1:0] e [9];
  logic signed [AW-1:0] s_sum, sc, sr, scr, scc, srr, a4_c, a5_c;

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      z[k] = in_samp[k];
      if (in_mode == MODE_ROW && (k < 3 || k > 5)) z[k] = '0;
      if (in_mode == MODE_COL && (k % 3) != 1) z[k] = '0;
      e[k] = AW'(z[k]);
    end
    s_sum = e[0] + e[1] + e[2] + e[3] + e[4] + e[5] + e[6] + e[7] + e[8];
    sc    = (e[2] + e[5] + e[8]) - (e[0] + e[3] + e[6]);
    sr    = (e[6] + e[7] + e[8]) - (e[0] + e[1] + e[2]);
    scr   = e[0] - e[2] - e[6] + e[8];
    scc   = e[0] + e[2] + e[3] + e[5] + e[6] + e[8];
    srr   = e[0] + e[1] + e[2] + e[6] + e[7] + e[8];
    a4_c  = (scc <<< 1) + scc - (s_sum <<< 1);
    a5_c  = (srr <<< 1) + srr - (s_sum <<< 1);
  end

  logic v1, v2, v3, en1, en2, en3;
  logic signed [AW-1:0] a1, a2, a3, a4, a5;
  logic [COORD_BITS-1:0] row1, col1, row2, col2, row3, col3;
  logic ctr1, ctr2;
  logic signed [MW-1:0] p33, p45, p15, p23, p24, p13;

  assign en3      = !v3 || out_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      a1   <= sc;
      a2   <= sr;
      a3   <= scr;
      a4   <= a4_c;
      a5   <= a5_c;
      row1 <= in_row;
      col1 <= in_col;
      ctr1 <= (in_mode == MODE_CENTRE);
    end
    if (en2) begin
      p33  <= a3 * a3;
      p45  <= a4 * a5;
      p15  <= a1 * a5;
      p23  <= a2 * a3;
      p24  <= a2 * a4;
      p13  <= a1 * a3;
      row2 <= row1;
      col2 <= col1;
      ctr2 <= ctr1;
    end
  end

  logic signed [PW-1:0] x33, x45, x15, x23, x24, x13, bot, cnum, rnum;

  always_comb begin
    x33  = PW'(p33);
    x45  = PW'(p45);
    x15  = PW'(p15);
    x23  = PW'(p23);
    x24  = PW'(p24);
    x13  = PW'(p13);
    bot  = (x33 <<< 3) + x33 - (x45 <<< 4);
    cnum = (x15 <<< 3) - (x23 <<< 2) - (x23 <<< 1);
    rnum = (x24 <<< 3) - (x13 <<< 2) - (x13 <<< 1);
    if (bot == '0) bot = PW'(1);
    if (ctr2) begin
      cnum = '0;
      rnum = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      out_dmag    <= bot[PW-1]  ? PW'(-bot)  : PW'(bot);
      out_ncol    <= cnum[PW-1] ? PW'(-cnum) : PW'(cnum);
      out_nrow    <= rnum[PW-1] ? PW'(-rnum) : PW'(rnum);
      out_neg_col <= cnum[PW-1] ^ bot[PW-1];
      out_neg_row <= rnum[PW-1] ^ bot[PW-1];
      row3        <= row2;
      col3        <= col2;
    end
  end

  assign out_valid = v3;
  assign out_row   = row3;
  assign out_col   = col3;

endmodule

// File: hdl/qfsp_div.sv
// ----------------------------------------------------------------------------
// qfsp_div
// Pipelined restoring divider, two lanes, one quotient bit per stage, with
// clipping of large quotients and round-half-up on the magnitude.
// ----------------------------------------------------------------------------
module qfsp_div #(
  parameter int COORD_BITS  = qfsp_pkg::COORD_BITS_DEF,
  parameter int SAMPLE_BITS = qfsp_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = qfsp_pkg::FRAC_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [COORD_BITS-1:0]                   in_row,
  input  logic [COORD_BITS-1:0]                   in_col,
  input  logic [2*SAMPLE_BITS+16:0]               in_dmag,
  input  logic [2*SAMPLE_BITS+16:0]               in_ncol,
  input  logic [2*SAMPLE_BITS+16:0]               in_nrow,
  input  logic                                    in_neg_col,
  input  logic                                    in_neg_row,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [COORD_BITS-1:0]                   out_row,
  output logic [COORD_BITS-1:0]                   out_col,
  output logic signed [COORD_BITS+FRAC_BITS+3:0]  out_off_row,
  output logic signed [COORD_BITS+FRAC_BITS+3:0]  out_off_col
);
  import qfsp_pkg::*;

  localparam int PW = 2 * SAMPLE_BITS + 17;
  localparam int Q  = COORD_BITS + FRAC_BITS + 2;
  localparam int RW = PW + FRAC_BITS + Q;
  localparam int OW = Q + 2;

  logic [Q+1:0] v, en;
  logic [RW-1:0] rc_st [Q+1];
  logic [RW-1:0] rr_st [Q+1];
  logic [Q-1:0] qc_st [Q+1];
  logic [Q-1:0] qr_st [Q+1];
  logic [PW-1:0] d_st [Q+1];
  logic [Q:0] ovc_st, ovr_st, ngc_st, ngr_st;
  logic [COORD_BITS-1:0] row_st [Q+1];
  logic [COORD_BITS-1:0] col_st [Q+1];

  assign en[Q+1]   = !v[Q+1] || out_ready;
  assign in_ready  = en[0];
  assign out_valid = v[Q+1];

  for (genvar j = 0; j <= Q; j++) begin : g_en
    assign en[j] = !v[j] || en[j+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int j = 1; j <= Q + 1; j++) begin
        if (en[j]) v[j] <= v[j-1];
      end
    end
  end

  logic [RW-1:0] n_c, n_r, dq;

  always_comb begin
    n_c = RW'(in_ncol) << FRAC_BITS;
    n_r = RW'(in_nrow) << FRAC_BITS;
    dq  = RW'(in_dmag) << Q;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rc_st[0]  <= n_c;
      rr_st[0]  <= n_r;
      qc_st[0]  <= '0;
      qr_st[0]  <= '0;
      d_st[0]   <= in_dmag;
      ovc_st[0] <= (n_c >= dq);
      ovr_st[0] <= (n_r >= dq);
      ngc_st[0] <= in_neg_col;
      ngr_st[0] <= in_neg_row;
      row_st[0] <= in_row;
      col_st[0] <= in_col;
    end
  end

  for (genvar j = 0; j < Q; j++) begin : g_bit
    localparam int BI = Q - 1 - j;
    logic [RW-1:0] dsh;
    logic ge_c, ge_r;

    assign dsh  = RW'(d_st[j]) << BI;
    assign ge_c = rc_st[j] >= dsh;
    assign ge_r = rr_st[j] >= dsh;

    always_ff @(posedge clk) begin
      if (en[j+1]) begin
        rc_st[j+1]  <= ge_c ? rc_st[j] - dsh : rc_st[j];
        rr_st[j+1]  <= ge_r ? rr_st[j] - dsh : rr_st[j];
        qc_st[j+1]  <= ge_c ? (qc_st[j] | (Q'(1) << BI)) : qc_st[j];
        qr_st[j+1]  <= ge_r ? (qr_st[j] | (Q'(1) << BI)) : qr_st[j];
        d_st[j+1]   <= d_st[j];
        ovc_st[j+1] <= ovc_st[j];
        ovr_st[j+1] <= ovr_st[j];
        ngc_st[j+1] <= ngc_st[j];
        ngr_st[j+1] <= ngr_st[j];
        row_st[j+1] <= row_st[j];
        col_st[j+1] <= col_st[j];
      end
    end
  end

  logic [RW-1:0] dfin;
  logic rnd_c, rnd_r;
  logic [Q:0] mag_c, mag_r;

  always_comb begin
    dfin  = RW'(d_st[Q]);
    rnd_c = (rc_st[Q] << 1) >= dfin;
    rnd_r = (rr_st[Q] << 1) >= dfin;
    mag_c = ovc_st[Q] ? ((Q+1)'(1) << Q) : ({1'b0, qc_st[Q]} + (Q+1)'(rnd_c));
    mag_r = ovr_st[Q] ? ((Q+1)'(1) << Q) : ({1'b0, qr_st[Q]} + (Q+1)'(rnd_r));
  end

  always_ff @(posedge clk) begin
    if (en[Q+1]) begin
      out_off_col <= ngc_st[Q] ? -OW'(mag_c) : OW'(mag_c);
      out_off_row <= ngr_st[Q] ? -OW'(mag_r) : OW'(mag_r);
      out_row     <= row_st[Q];
      out_col     <= col_st[Q];
    end
  end

endmodule

// File: hdl/qfsp_place.sv
// ----------------------------------------------------------------------------
// qfsp_place
// Output stage: peak plus offset in fixed point, saturated, with flag.
// ----------------------------------------------------------------------------
module qfsp_place #(
  parameter int COORD_BITS = qfsp_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = qfsp_pkg::FRAC_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [COORD_BITS-1:0]                   in_row,
  input  logic [COORD_BITS-1:0]                   in_col,
  input  logic signed [COORD_BITS+FRAC_BITS+3:0]  in_off_row,
  input  logic signed [COORD_BITS+FRAC_BITS+3:0]  in_off_col,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [COORD_BITS+FRAC_BITS:0]    out_ref_row,
  output logic signed [COORD_BITS+FRAC_BITS:0]    out_ref_col,
  output logic                                    out_sat
);
  import qfsp_pkg::*;

  localparam int OUT = COORD_BITS + FRAC_BITS + 1;
  localparam int OW  = COORD_BITS + FRAC_BITS + 4;
  localparam int SW  = OW + 1;
  localparam logic signed [SW-1:0] HI = {{(SW-OUT+1){1'b0}}, {(OUT-1){1'b1}}};
  localparam logic signed [SW-1:0] LO = {{(SW-OUT+1){1'b1}}, {(OUT-1){1'b0}}};

  logic v, en;
  logic signed [SW-1:0] pr, pc;
  logic signed [OUT-1:0] rr, rc;
  logic sr_hi, sr_lo, sc_hi, sc_lo;

  assign en        = !v || out_ready;
  assign in_ready  = en;
  assign out_valid = v;

  always_comb begin
    pr    = SW'({1'b0, in_row, {FRAC_BITS{1'b0}}}) + SW'(in_off_row);
    pc    = SW'({1'b0, in_col, {FRAC_BITS{1'b0}}}) + SW'(in_off_col);
    sr_hi = pr > HI;
    sr_lo = pr < LO;
    sc_hi = pc > HI;
    sc_lo = pc < LO;
    rr    = sr_hi ? OUT'(HI) : (sr_lo ? OUT'(LO) : OUT'(pr));
    rc    = sc_hi ? OUT'(HI) : (sc_lo ? OUT'(LO) : OUT'(pc));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (en) begin
      v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ref_row <= rr;
      out_ref_col <= rc;
      out_sat     <= sr_hi | sr_lo | sc_hi | sc_lo;
    end
  end

endmodule

// File: hdl/quadratic_fit_subpixel_peak.sv
// ----------------------------------------------------------------------------
// quadratic_fit_subpixel_peak
// Refines an integer correlation peak to sub-pixel precision by fitting a
// quadratic surface over its 3x3 neighbourhood.
//
//   channel  dir  tdata                               tuser
//   s_*      in   peak_row, peak_col, 9 samples       edge_mode
//   m_*      out  refined_row, refined_col            fit_success, saturated
//
// One beat per cycle sustained while m_* is not stalled. The pipeline holds
// three fit stages, one divider stage per quotient bit plus setup and rounding
// stages, and the output register.
// Reset clears all valid bits; no clearing pass.
// A stall on m_* holds each stage only while the stage after it is full, so
// bubbles close up and beats keep entering until the pipeline is full.
// ----------------------------------------------------------------------------
module quadratic_fit_subpixel_peak #(
  parameter int COORD_BITS  = qfsp_pkg::COORD_BITS_DEF,
  parameter int SAMPLE_BITS = qfsp_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = qfsp_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // peak_row, peak_col, sample_tl..sample_br, zero fill
  input  logic [((2*COORD_BITS+9*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
  // edge_mode
  input  logic [1:0] s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // refined_row, refined_col, zero fill
  output logic [((2*(COORD_BITS+FRAC_BITS+1)+7)/8)*8-1:0] m_tdata,
  // fit_success, saturated
  output logic [1:0] m_tuser
);
  import qfsp_pkg::*;

  localparam int PW  = 2 * SAMPLE_BITS + 17;
  localparam int OUT = COORD_BITS + FRAC_BITS + 1;
  localparam int OW  = COORD_BITS + FRAC_BITS + 4;
  localparam int MDW = ((2 * OUT + 7) / 8) * 8;

  logic signed [SAMPLE_BITS-1:0] samp [9];

  for (genvar k = 0; k < 9; k++) begin : g_samp
    assign samp[k] = s_tdata[2*COORD_BITS + k*SAMPLE_BITS +: SAMPLE_BITS];
  end

  logic f_valid, f_ready, d_valid, d_ready, sat;
  logic [COORD_BITS-1:0] f_row, f_col, d_row, d_col;
  logic [PW-1:0] f_dmag, f_ncol, f_nrow;
  logic f_ngc, f_ngr;
  logic signed [OW-1:0] d_offr, d_offc;
  logic signed [OUT-1:0] ref_row, ref_col;

  qfsp_fit #(
    .COORD_BITS (COORD_BITS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_fit (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_row     (s_tdata[COORD_BITS-1:0]),
    .in_col     (s_tdata[2*COORD_BITS-1:COORD_BITS]),
    .in_mode    (edge_mode_t'(s_tuser)),
    .in_samp    (samp),
    .out_valid  (f_valid),
    .out_ready  (f_ready),
    .out_row    (f_row),
    .out_col    (f_col),
    .out_dmag   (f_dmag),
    .out_ncol   (f_ncol),
    .out_nrow   (f_nrow),
    .out_neg_col(f_ngc),
    .out_neg_row(f_ngr)
  );

  qfsp_div #(
    .COORD_BITS (COORD_BITS),
    .SAMPLE_BITS(SAMPLE_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_div (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (f_valid),
    .in_ready   (f_ready),
    .in_row     (f_row),
    .in_col     (f_col),
    .in_dmag    (f_dmag),
    .in_ncol    (f_ncol),
    .in_nrow    (f_nrow),
    .in_neg_col (f_ngc),
    .in_neg_row (f_ngr),
    .out_valid  (d_valid),
    .out_ready  (d_ready),
    .out_row    (d_row),
    .out_col    (d_col),
    .out_off_row(d_offr),
    .out_off_col(d_offc)
  );

  qfsp_place #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_place (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (d_valid),
    .in_ready   (d_ready),
    .in_row     (d_row),
    .in_col     (d_col),
    .in_off_row (d_offr),
    .in_off_col (d_offc),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_ref_row(ref_row),
    .out_ref_col(ref_col),
    .out_sat    (sat)
  );

  assign m_tdata = MDW'({ref_col, ref_row});
  assign m_tuser = {sat, 1'b1};

`ifndef SYNTH
  localparam logic signed [OUT-1:0] OUT_HI = {1'b0, {(OUT-1){1'b1}}};
  localparam logic signed [OUT-1:0] OUT_LO = {1'b1, {(OUT-1){1'b0}}};

  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && sat) |-> (ref_row == OUT_HI || ref_row == OUT_LO ||
                           ref_col == OUT_HI || ref_col == OUT_LO))
    else $error("saturated flag without a clipped coordinate");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while output register is empty");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");
`endif

endmodule

// File: dv/qfsp_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// qfsp_checker
// Watches both stream channels, predicts each refined peak from the accepted
// neighbourhood and compares it with the next output beat.
// ----------------------------------------------------------------------------
module qfsp_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [167:0] s_tdata,
  input  logic [1:0]   s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [47:0]  m_tdata,
  input  logic [1:0]   m_tuser,
  output int           fail_count,
  output int           pending
);
  import qfsp_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam int SB = SAMPLE_BITS_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int OB = CB + FB + 1;

  typedef struct packed {
    logic [OB-1:0] row;
    logic [OB-1:0] col;
    logic          success;
    logic          sat;
  } peak_res_t;

  peak_res_t refined_q[$];

  // round-to-nearest, ties away from zero; magnitude clipped to 2^40
  function automatic longint fit_offset(logic signed [127:0] num, logic signed [127:0] bot);
    logic [127:0] n, d, q, r;
    logic         neg;
    neg = num[127] ^ bot[127];
    n = num[127] ? -num : num;
    d = bot[127] ? -bot : bot;
    n = n << FB;
    q = n / d;
    r = n % d;
    if ((r << 1) >= d) q = q + 1;
    if (q > (128'd1 << 40)) q = 128'd1 << 40;
    return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic logic [OB-1:0] place_peak(longint pk, longint off, inout logic sat);
    longint p;
    p = pk * (64'sd1 << FB) + off;
    if (p > (64'sd1 << (OB-1)) - 1) begin
      p = (64'sd1 << (OB-1)) - 1;
      sat = 1'b1;
    end
    if (p < -(64'sd1 << (OB-1))) begin
      p = -(64'sd1 << (OB-1));
      sat = 1'b1;
    end
    return p[OB-1:0];
  endfunction

  function automatic peak_res_t refine_peak(logic [167:0] d, edge_mode_t mode);
    longint z[3][3];
    longint s, sc, sr, scr, scc, srr, a4, a5;
    logic signed [127:0] bot, cnum, rnum;
    longint roff, coff;
    logic sat;
    peak_res_t res;
    for (int i = 0; i < 9; i++)
      z[i/3][i%3] = longint'($signed(d[2*CB+i*SB +: SB]));
    if (mode == MODE_ROW)
      for (int c = 0; c < 3; c++) begin
        z[0][c] = 0;
        z[2][c] = 0;
      end
    if (mode == MODE_COL)
      for (int r = 0; r < 3; r++) begin
        z[r][0] = 0;
        z[r][2] = 0;
      end
    roff = 0;
    coff = 0;
    sat = 1'b0;
    if (mode != MODE_CENTRE) begin
      s = 0;
      foreach (z[r, c]) s += z[r][c];
      sc = z[0][2] + z[1][2] + z[2][2] - z[0][0] - z[1][0] - z[2][0];
      sr = z[2][0] + z[2][1] + z[2][2] - z[0][0] - z[0][1] - z[0][2];
      scr = z[0][0] - z[0][2] - z[2][0] + z[2][2];
      scc = z[0][0] + z[0][2] + z[1][0] + z[1][2] + z[2][0] + z[2][2];
      srr = z[0][0] + z[0][1] + z[0][2] + z[2][0] + z[2][1] + z[2][2];
      a4 = 3 * scc - 2 * s;
      a5 = 3 * srr - 2 * s;
      bot = 128'(9 * scr) * scr - 128'(16 * a4) * a5;
      cnum = 128'(8 * sc) * a5 - 128'(6 * sr) * scr;
      rnum = 128'(8 * sr) * a4 - 128'(6 * sc) * scr;
      if (bot == 0) bot = 1;
      coff = fit_offset(cnum, bot);
      roff = fit_offset(rnum, bot);
    end
    res.row = place_peak(longint'(d[CB-1:0]), roff, sat);
    res.col = place_peak(longint'(d[2*CB-1:CB]), coff, sat);
    res.success = 1'b1;
    res.sat = sat;
    return res;
  endfunction

  assign pending = refined_q.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    peak_res_t want;
    if (!rst) begin
      if (s_tvalid && s_tready)
        refined_q.push_back(refine_peak(s_tdata, edge_mode_t'(s_tuser)));
      if (m_tvalid && m_tready) begin
        if (refined_q.size() == 0) begin
          $error("unexpected output beat %h", m_tdata);
          fail_count++;
        end else begin
          want = refined_q.pop_front();
          if (m_tdata[OB-1:0] !== want.row) begin
            $error("refined_row exp %h got %h", want.row, m_tdata[OB-1:0]);
            fail_count++;
          end
          if (m_tdata[2*OB-1:OB] !== want.col) begin
            $error("refined_col exp %h got %h", want.col, m_tdata[2*OB-1:OB]);
            fail_count++;
          end
          if (m_tuser[0] !== want.success) begin
            $error("fit_success exp %b got %b", want.success, m_tuser[0]);
            fail_count++;
          end
          if (m_tuser[1] !== want.sat) begin
            $error("saturated exp %b got %b", want.sat, m_tuser[1]);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random neighbourhoods into the sub-pixel peak refiner
// with random gaps and back-pressure; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
  import qfsp_pkg::*;

  localparam int N_RANDOM = 2000;
  localparam int LIMIT    = 400000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [167:0] s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [47:0]  m_tdata;
  logic [1:0]   m_tuser;
  int           fail_count;
  int           pending;
  int           cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  quadratic_fit_subpixel_peak DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  qfsp_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .fail_count(fail_count), .pending(pending)
  );

  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 5);
  endfunction

  function automatic logic [15:0] pick_sample(int kind);
    case (kind)
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'(int'($urandom_range(64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  // send one beat, holding valid until accepted
  task automatic send_beat(logic [11:0] row, logic [11:0] col, edge_mode_t mode,
                           logic [143:0] samples);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tdata  <= {samples, col, row};
    s_tuser  <= mode;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_random();
    logic [143:0] smp;
    int shape;
    shape = $urandom_range(9);
    for (int i = 0; i < 9; i++)
      smp[i*16 +: 16] = pick_sample(shape < 6 ? 4 : (shape < 8 ? 3 : $urandom_range(4)));
    // peak-like surface: centre dominates
    if (shape < 3) smp[4*16 +: 16] = 16'h7000 + 16'($urandom_range(4095));
    send_beat($urandom_range(9) == 0 ? 12'hfff : 12'($urandom),
              $urandom_range(9) == 0 ? 12'h000 : 12'($urandom),
              edge_mode_t'($urandom_range(3)), smp);
  endtask

  // receiver: random stalls, short and long
  initial begin
    int g;
    @(negedge rst);
    forever begin
      g = gap_len();
      if (g > 0) begin
        m_tready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(8, 1)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic [143:0] flat;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_beat(12'h000, 12'h000, MODE_FULL, {9{16'h7fff}});
    send_beat(12'hfff, 12'hfff, MODE_FULL, {9{16'h8000}});
    send_beat(12'h000, 12'hfff, MODE_FULL, '0);
    send_beat(12'h800, 12'h7ff, MODE_FULL,
              {16'h1000, 16'h2000, 16'h1000, 16'h2000, 16'h7fff,
               16'h2000, 16'h1000, 16'h2000, 16'h1000});
    send_beat(12'h123, 12'h456, MODE_ROW,
              {16'h8000, 16'h7fff, 16'h8000, 16'h1000, 16'h4000,
               16'h3000, 16'h7fff, 16'h8000, 16'h7fff});
    send_beat(12'h321, 12'h654, MODE_COL,
              {16'h7fff, 16'h2000, 16'h8000, 16'h8000, 16'h6000,
               16'h7fff, 16'h8000, 16'h1000, 16'h7fff});
    send_beat(12'hfff, 12'h000, MODE_CENTRE, {9{16'h5a5a}});
    send_beat(12'h000, 12'h000, MODE_CENTRE, {9{16'ha5a5}});
    // planar surface: zero denominator
    send_beat(12'h400, 12'h400, MODE_FULL,
              {16'd300, 16'd200, 16'd100, 16'd200, 16'd100,
               16'd0, 16'd100, 16'd0, 16'hff9c});
    send_beat(12'h010, 12'h020, MODE_ROW, {48'h0, 16'd5, 16'd0, 16'hfffb, 48'h0});
    send_beat(12'h000, 12'hfff, MODE_COL, '0);
    send_beat(12'hfff, 12'h000, MODE_FULL,
              {16'h8000, 16'h0, 16'h7fff, 16'h0, 16'h0, 16'h0, 16'h7fff, 16'h0, 16'h8000});
    for (int i = 0; i < 9; i++) begin
      flat = '0;
      flat[i*16 +: 16] = 16'h7fff;
      send_beat(12'(i * 455), 12'(4095 - i * 455), edge_mode_t'(i % 4), flat);
    end
    repeat (N_RANDOM) send_random();
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
